/* hw/rtl/gsl_pkg.sv */
// Package for the geodesic scalar Laplacian block.
// Holds fixed-point constants and the sequencer state type.
// No dependencies.
package gsl_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int WORD_W      = 32;
  localparam int DIV_STEPS   = WORD_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam int DMAG_W      = WORD_W + 1;

  localparam logic [WORD_W-1:0] SAT_POS = WORD_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
  localparam logic [WORD_W-1:0] SAT_NEG = WORD_W'(64'd1 << (VALUE_WIDTH - 1));
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(DIV_STEPS - 1);

  localparam logic [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

  localparam logic [WORD_W-1:0] VISC_RESET = WORD_W'(65536);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QSETUP,
    ST_QDIV,
    ST_QSAT,
    ST_QMUL,
    ST_QACC,
    ST_RABS,
    ST_RMUL0,
    ST_RMUL1,
    ST_RSUM,
    ST_RCHK,
    ST_RDIV,
    ST_RSAT
  } state_t;

endpackage

/* hw/rtl/geodesic_scalar_laplacian.sv */
// A term beat runs setup, the divider (skipped when the quotient is zero or clips early),
// saturate, multiply and accumulate before the next accept; a last term adds the result states.
// Throughput is set by the shared 32-step radix-2 divider, used at most once per term and once per cell.
// One 32x32 multiplier is shared for the term product and the two result partial products.
// Reset (rst, synchronous): sequencer idle, running sum and clip flag cleared, output
// empty, viscosity back to 1.0.
//
// Top level: finite-volume scalar diffusion on a geodesic mesh, Q16.16.
// Depends on gsl_pkg.
module geodesic_scalar_laplacian (
  input  logic               clk,
  input  logic               rst,
  input  logic               viscosity_wr_en,
  input  logic        [31:0] viscosity_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] center_value,
  input  logic signed [31:0] neighbor_value,
  input  logic        [31:0] node_distance,
  input  logic        [31:0] edge_length,
  input  logic        [31:0] cell_area,
  input  logic               last_term,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] diffusion_value,
  output logic               saturated
);

  gsl_pkg::state_t state, state_next;

  logic [31:0] viscosity;
  logic [63:0] sum;
  logic        clip;

  logic                       dneg;
  logic [gsl_pkg::DMAG_W-1:0] dmag;
  logic [31:0]                node_dist;
  logic [31:0]                span_len;
  logic [31:0]                area;
  logic                       last;

  logic [31:0]                div_rem;
  logic [31:0]                div_q;
  logic [31:0]                div_d;
  logic [gsl_pkg::CNT_W-1:0]  cnt;

  logic [63:0] mul_p;
  logic [63:0] prod_lo;
  logic [63:0] rhi;
  logic        sneg;
  logic [63:0] smag;

  logic signed [32:0]         diff;
  logic [63:0]                dividend;
  logic                       q_fast;
  logic [32:0]                shifted;
  logic                       div_ge;
  logic [32:0]                sub_res;
  logic [31:0]                mul_a;
  logic [31:0]                mul_b;
  logic [63:0]                tmag;
  logic [64:0]                acc;
  logic                       acc_ovf;
  logic [31:0]                q_lim;
  logic [31:0]                r_lim;
  logic                       r_fast;
  logic                       r_zero;
  logic                       out_free;
  logic                       rclip;
  logic [31:0]                rmag;

  assign diff     = {neighbor_value[31], neighbor_value} - {center_value[31], center_value};
  assign dividend = 64'(dmag) << gsl_pkg::FRAC_BITS;
  assign q_fast   = (dmag == '0) || (dividend[63:32] >= node_dist);

  assign shifted  = {div_rem, div_q[31]};
  assign sub_res  = shifted - {1'b0, div_d};
  assign div_ge   = shifted >= {1'b0, div_d};

  assign tmag     = mul_p >> gsl_pkg::FRAC_BITS;
  assign acc      = dneg ? ({sum[63], sum} - {1'b0, tmag}) : ({sum[63], sum} + {1'b0, tmag});
  assign acc_ovf  = acc[64] != acc[63];

  assign q_lim    = dneg ? gsl_pkg::SAT_NEG : gsl_pkg::SAT_POS;
  assign r_lim    = sneg ? gsl_pkg::SAT_NEG : gsl_pkg::SAT_POS;
  assign r_zero   = (rhi == '0) && (prod_lo[31:0] == '0);
  assign r_fast   = r_zero || (rhi >= {32'd0, area});
  assign rclip    = div_q > r_lim;
  assign rmag     = rclip ? r_lim : div_q;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      gsl_pkg::ST_IDLE:   if (in_valid) state_next = gsl_pkg::ST_QSETUP;
      gsl_pkg::ST_QSETUP: state_next = q_fast ? gsl_pkg::ST_QSAT : gsl_pkg::ST_QDIV;
      gsl_pkg::ST_QDIV:   if (cnt == gsl_pkg::CNT_LAST) state_next = gsl_pkg::ST_QSAT;
      gsl_pkg::ST_QSAT:   state_next = gsl_pkg::ST_QMUL;
      gsl_pkg::ST_QMUL:   state_next = gsl_pkg::ST_QACC;
      gsl_pkg::ST_QACC:   state_next = last ? gsl_pkg::ST_RABS : gsl_pkg::ST_IDLE;
      gsl_pkg::ST_RABS:   state_next = gsl_pkg::ST_RMUL0;
      gsl_pkg::ST_RMUL0:  state_next = gsl_pkg::ST_RMUL1;
      gsl_pkg::ST_RMUL1:  state_next = gsl_pkg::ST_RSUM;
      gsl_pkg::ST_RSUM:   state_next = gsl_pkg::ST_RCHK;
      gsl_pkg::ST_RCHK:   state_next = r_fast ? gsl_pkg::ST_RSAT : gsl_pkg::ST_RDIV;
      gsl_pkg::ST_RDIV:   if (cnt == gsl_pkg::CNT_LAST) state_next = gsl_pkg::ST_RSAT;
      gsl_pkg::ST_RSAT:   if (out_free) state_next = gsl_pkg::ST_IDLE;
      default:            state_next = gsl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mul_a    = div_q;
    mul_b    = span_len;
    case (state)
      gsl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      gsl_pkg::ST_RMUL0: begin
        mul_a = smag[31:0];
        mul_b = viscosity;
      end
      gsl_pkg::ST_RMUL1: begin
        mul_a = smag[63:32];
        mul_b = viscosity;
      end
      default: begin
        mul_a = div_q;
        mul_b = span_len;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gsl_pkg::ST_IDLE;
      viscosity <= gsl_pkg::VISC_RESET;
      sum       <= '0;
      clip      <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (viscosity_wr_en) viscosity <= viscosity_wr_data;
      if (state == gsl_pkg::ST_RSAT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        gsl_pkg::ST_IDLE: begin
          if (in_valid) begin
            dneg      <= diff[32];
            dmag      <= diff[32] ? 33'd0 - 33'(diff) : 33'(diff);
            node_dist <= node_distance;
            span_len  <= edge_length;
            area      <= cell_area;
            last      <= last_term;
          end
        end
        gsl_pkg::ST_QSETUP: begin
          cnt <= '0;
          if (dmag == '0) begin
            div_q <= '0;
          end else if (dividend[63:32] >= node_dist) begin
            div_q <= '1;
          end else begin
            div_rem <= dividend[63:32];
            div_q   <= dividend[31:0];
            div_d   <= node_dist;
          end
        end
        gsl_pkg::ST_QDIV, gsl_pkg::ST_RDIV: begin
          div_rem <= div_ge ? sub_res[31:0] : shifted[31:0];
          div_q   <= {div_q[30:0], div_ge};
          cnt     <= cnt + 1'b1;
        end
        gsl_pkg::ST_QSAT: begin
          if (div_q > q_lim) begin
            div_q <= q_lim;
            clip  <= 1'b1;
          end
        end
        gsl_pkg::ST_QMUL: begin
          mul_p <= mul_a * mul_b;
        end
        gsl_pkg::ST_QACC: begin
          if (acc_ovf) begin
            sum  <= dneg ? gsl_pkg::SUM_MIN : gsl_pkg::SUM_MAX;
            clip <= 1'b1;
          end else begin
            sum <= acc[63:0];
          end
        end
        gsl_pkg::ST_RABS: begin
          sneg <= sum[63];
          smag <= sum[63] ? 64'd0 - sum : sum;
        end
        gsl_pkg::ST_RMUL0: begin
          mul_p <= mul_a * mul_b;
        end
        gsl_pkg::ST_RMUL1: begin
          prod_lo <= mul_p;
          mul_p   <= mul_a * mul_b;
        end
        gsl_pkg::ST_RSUM: begin
          rhi <= mul_p + {32'd0, prod_lo[63:32]};
        end
        gsl_pkg::ST_RCHK: begin
          cnt <= '0;
          if (r_zero) begin
            div_q <= '0;
          end else if (rhi >= {32'd0, area}) begin
            div_q <= '1;
          end else begin
            div_rem <= rhi[31:0];
            div_q   <= prod_lo[31:0];
            div_d   <= area;
          end
        end
        gsl_pkg::ST_RSAT: begin
          if (out_free) begin
            diffusion_value <= sneg ? 32'd0 - rmag : rmag;
            saturated       <= clip || rclip;
            sum             <= '0;
            clip            <= 1'b0;
          end
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/gsl_checker.sv */
// Port-level checker for geodesic_scalar_laplacian, bound to the top level.
// Depends only on the top level's ports.
module gsl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] diffusion_value,
  input logic        saturated
);

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(diffusion_value) && $stable(saturated))
    else $error("result beat changed while stalled");

  // one term at a time: busy right after an input beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a term is in progress");

  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after an input beat");

  // a result is posted only as the sequencer returns to idle
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result posted while sequencer busy");

endmodule

bind geodesic_scalar_laplacian gsl_checker u_gsl_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .diffusion_value (diffusion_value),
  .saturated       (saturated)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench for geodesic_scalar_laplacian: a directed table of neighbor terms, then random cells.
// Checks results against typed rows or a Q16.16 flux accumulator. Needs gsl_pkg and the RTL.
module tb;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic signed [31:0] center;
    logic signed [31:0] neighbor;
    logic [31:0]        node_dist;
    logic [31:0]        span_len;
    logic [31:0]        area;
    logic               last;
  } nbr_term_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } cell_result_t;

  typedef struct packed {
    nbr_term_t    t;
    logic         typed;
    cell_result_t want;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               viscosity_wr_en;
  logic        [31:0] viscosity_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] center_value;
  logic signed [31:0] neighbor_value;
  logic        [31:0] node_distance;
  logic        [31:0] edge_length;
  logic        [31:0] cell_area;
  logic               last_term;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] diffusion_value;
  logic               saturated;

  // flux accumulator shadow
  logic [63:0] flux_sum;
  logic        flux_clipped;
  logic [31:0] visc_shadow;

  cell_result_t diffusion_q[$];
  dir_row_t     dir_rows[$];
  int           miss_count;
  int           items_sent;
  int           stall_cycles;
  int           tx_idle_pct;
  int           rx_idle_pct;
  bit           hold_req;

  geodesic_scalar_laplacian u_dut (
    .clk               (clk),
    .rst               (rst),
    .viscosity_wr_en   (viscosity_wr_en),
    .viscosity_wr_data (viscosity_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .center_value      (center_value),
    .neighbor_value    (neighbor_value),
    .node_distance     (node_distance),
    .edge_length       (edge_length),
    .cell_area         (cell_area),
    .last_term         (last_term),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .diffusion_value   (diffusion_value),
    .saturated         (saturated)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Adds one term to the flux sum; on a last term returns 1 with the cell result.
  function automatic bit fold_term(input nbr_term_t t, output cell_result_t r);
    longint       diff;
    logic [63:0]  dmag, qmag, lim, tmag, smag;
    logic [127:0] prod;
    logic [65:0]  acc_w;
    bit           neg, sneg, rclip;
    diff = longint'(t.neighbor) - longint'(t.center);
    neg = diff < 0;
    dmag = neg ? 64'(-diff) : 64'(diff);
    lim = neg ? 64'(gsl_pkg::SAT_NEG) : 64'(gsl_pkg::SAT_POS);
    if (t.node_dist == 0) begin
      qmag = (dmag == 0) ? 64'd0 : '1;
    end else begin
      qmag = (dmag << gsl_pkg::FRAC_BITS) / 64'(t.node_dist);
    end
    if (qmag > lim) begin
      qmag = lim;
      flux_clipped = 1'b1;
    end
    prod = (128'(qmag) * 128'(t.span_len)) >> gsl_pkg::FRAC_BITS;
    if (prod > 128'(gsl_pkg::SUM_MAX)) begin
      tmag = gsl_pkg::SUM_MAX;
      flux_clipped = 1'b1;
    end else begin
      tmag = prod[63:0];
    end
    acc_w = {{2{flux_sum[63]}}, flux_sum} + (neg ? -{2'b00, tmag} : {2'b00, tmag});
    if (acc_w[65:63] == 3'b000 || acc_w[65:63] == 3'b111) begin
      flux_sum = acc_w[63:0];
    end else begin
      flux_sum = acc_w[65] ? gsl_pkg::SUM_MIN : gsl_pkg::SUM_MAX;
      flux_clipped = 1'b1;
    end
    if (!t.last) return 1'b0;

    sneg = flux_sum[63];
    smag = sneg ? -flux_sum : flux_sum;
    if (smag == 0 || visc_shadow == 0) begin
      prod = '0;
    end else if (t.area == 0) begin
      prod = '1;
    end else begin
      prod = (128'(smag) * 128'(visc_shadow)) / 128'(t.area);
    end
    rclip = 1'b0;
    lim = sneg ? 64'(gsl_pkg::SAT_NEG) : 64'(gsl_pkg::SAT_POS);
    if (prod > 128'(lim)) begin
      prod = 128'(lim);
      rclip = 1'b1;
    end
    r.value = sneg ? -prod[31:0] : prod[31:0];
    r.sat = flux_clipped | rclip;
    flux_sum = '0;
    flux_clipped = 1'b0;
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [31:0] c, input logic [31:0] n,
                                  input logic [31:0] d, input logic [31:0] e,
                                  input logic [31:0] a, input logic l,
                                  input bit typed = 1'b0, input logic [31:0] v = '0,
                                  input logic s = 1'b0);
    dir_row_t row;
    row.t = '{center: c, neighbor: n, node_dist: d, span_len: e, area: a, last: l};
    row.typed = typed;
    row.want = '{value: v, sat: s};
    dir_rows.push_back(row);
  endfunction

  function automatic logic [31:0] rand_scalar();
    case ($urandom_range(15))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3, 4, 5: return $urandom();
      default: return $urandom_range(32'h7F_FFFF) - 32'h40_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_length();
    case ($urandom_range(15))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1;
      3, 4: return $urandom();
      default: return $urandom_range(32'h4_0000, 32'h100);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_term(input nbr_term_t t, input bit typed, input cell_result_t typed_res);
    cell_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    center_value   <= t.center;
    neighbor_value <= t.neighbor;
    node_distance  <= t.node_dist;
    edge_length    <= t.span_len;
    cell_area      <= t.area;
    last_term      <= t.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (fold_term(t, r)) diffusion_q.push_back(typed ? typed_res : r);
    items_sent++;
    @(negedge clk);
  endtask

  // Well-formed cells are 5 or 6 terms sharing center and area; the rest are ragged runs.
  task automatic send_cell();
    nbr_term_t t;
    bit          shaped;
    int          n_terms;
    logic [31:0] c, a;
    shaped = $urandom_range(9) < 8;
    n_terms = shaped ? $urandom_range(6, 5) : $urandom_range(12, 1);
    c = rand_scalar();
    a = rand_length();
    for (int k = 0; k < n_terms; k++) begin
      t.center    = shaped ? c : rand_scalar();
      t.neighbor  = rand_scalar();
      t.node_dist = rand_length();
      t.span_len  = rand_length();
      t.area      = shaped ? a : rand_length();
      t.last      = (k == n_terms - 1) || (!shaped && $urandom_range(3) == 0);
      send_term(t, 1'b0, '0);
    end
  endtask

  task automatic settle_and_write(input logic [31:0] v);
    in_valid <= 1'b0;
    wait (diffusion_q.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    viscosity_wr_en   <= 1'b1;
    viscosity_wr_data <= v;
    @(posedge clk);
    visc_shadow = v;
    @(negedge clk);
    viscosity_wr_en <= 1'b0;
  endtask

  initial begin : result_side
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    cell_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (diffusion_q.size() == 0) begin
        $display("%0t: unexpected beat, got value %h sat %b", $time, diffusion_value, saturated);
        miss_count++;
      end else begin
        want = diffusion_q.pop_front();
        if (diffusion_value !== want.value) begin
          $display("%0t: diffusion_value expected %h got %h", $time, want.value, diffusion_value);
          miss_count++;
        end
        if (saturated !== want.sat) begin
          $display("%0t: saturated expected %b got %b", $time, want.sat, saturated);
          miss_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("geodesic_scalar_laplacian: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] visc_plan [6];
    int          target;
    bit          hold_done, pause_done;
    rst               = 1'b1;
    viscosity_wr_en   = 1'b0;
    viscosity_wr_data = '0;
    in_valid          = 1'b0;
    center_value      = '0;
    neighbor_value    = '0;
    node_distance     = '0;
    edge_length       = '0;
    cell_area         = '0;
    last_term         = 1'b0;
    flux_sum          = '0;
    flux_clipped      = 1'b0;
    visc_shadow       = gsl_pkg::VISC_RESET;
    items_sent        = 0;
    hold_req          = 1'b0;
    hold_done         = 1'b0;
    pause_done        = 1'b0;
    tx_idle_pct       = 38;
    rx_idle_pct       = 77;
    visc_plan = '{32'hFFFF_FFFF, 32'h0, 32'h1, $urandom(), 32'h0000_8000, $urandom()};

    // single term straight out of reset: empty sum
    add_row(32'h0, 32'h0, 32'h1, 32'h0, 32'h1, 1'b1, 1'b1, 32'h0, 1'b0);
    // hexagon
    add_row(32'h0001_8000, 32'h0002_0000, 32'h0001_0000, 32'h0000_9000, 32'h0002_8000, 1'b0);
    add_row(32'h0001_8000, 32'h0000_8000, 32'h0000_C000, 32'h0001_2000, 32'h0002_8000, 1'b0);
    add_row(32'h0001_8000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_F000, 32'h0002_8000, 1'b0);
    add_row(32'h0001_8000, 32'h0003_4000, 32'h0001_4000, 32'h0000_A800, 32'h0002_8000, 1'b0);
    add_row(32'h0001_8000, 32'h0001_8000, 32'h0000_0100, 32'h0001_0000, 32'h0002_8000, 1'b0);
    add_row(32'h0001_8000, 32'h0000_0001, 32'h0001_0000, 32'h0000_C400, 32'h0002_8000, 1'b1);
    // pentagon
    add_row(32'hFFFE_0000, 32'hFFFF_0000, 32'h0000_E000, 32'h0001_1000, 32'h0001_C000, 1'b0);
    add_row(32'hFFFE_0000, 32'hFFFC_8000, 32'h0001_2000, 32'h0000_D000, 32'h0001_C000, 1'b0);
    add_row(32'hFFFE_0000, 32'h0000_4000, 32'h0000_F800, 32'h0000_B800, 32'h0001_C000, 1'b0);
    add_row(32'hFFFE_0000, 32'hFFFD_0000, 32'h0001_0800, 32'h0001_0400, 32'h0001_C000, 1'b0);
    add_row(32'hFFFE_0000, 32'hFFFE_0001, 32'h0001_1800, 32'h0000_E800, 32'h0001_C000, 1'b1);
    // zero distance, both signs and no difference
    add_row(32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h1, 1'b1, 1'b1, gsl_pkg::SAT_POS,
            1'b1);
    add_row(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 32'h1, 1'b1, 1'b1, gsl_pkg::SAT_NEG,
            1'b1);
    add_row(32'h3039, 32'h3039, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 1'b1, 1'b1, 32'h0, 1'b0);
    // zero area with and without a sum
    add_row(32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 1'b1, 1'b1,
            gsl_pkg::SAT_POS, 1'b1);
    add_row(32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b1, 1'b1, 32'h0, 1'b0);
    // field extremes
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 1'b1, 1'b1,
            gsl_pkg::SAT_NEG, 1'b1);
    // no last mark for six terms: sum keeps running
    add_row(32'h0005_0000, 32'h0006_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 1'b0);
    add_row(32'h0005_0000, 32'h0004_8000, 32'h0000_C000, 32'h0001_4000, 32'h0003_0000, 1'b0);
    add_row(32'h0005_0000, 32'h0007_0000, 32'h0001_8000, 32'h0000_E000, 32'h0003_0000, 1'b0);
    add_row(32'h0005_0000, 32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 1'b0);
    add_row(32'h0005_0000, 32'h0005_4000, 32'h0000_8000, 32'h0000_9000, 32'h0003_0000, 1'b0);
    add_row(32'h0005_0000, 32'h0008_0000, 32'h0001_0000, 32'h0001_2000, 32'h0003_0000, 1'b0);
    add_row(32'h0005_0000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 1'b1);

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_term(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      tx_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 77 : 0;
      rx_idle_pct = (ph < 2) ? 77 : (ph < 4) ? 38 : 0;
      settle_and_write(visc_plan[ph]);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if (ph == 1 && !hold_done && items_sent >= target - 70) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        if (ph == 3 && !pause_done && items_sent >= target - 50) begin
          in_valid <= 1'b0;
          wait (diffusion_q.size() == 0);
          @(negedge clk);
          pause_done = 1'b1;
        end
        send_cell();
      end
    end

    in_valid <= 1'b0;
    wait (diffusion_q.size() == 0);
    repeat (100) @(posedge clk);
    if (miss_count == 0) begin
      $display("geodesic_scalar_laplacian: match");
    end else begin
      $display("geodesic_scalar_laplacian: mismatch");
    end
    $finish;
  end

endmodule
